>>> rtl/tgb_pkg.sv
`timescale 1ns / 1ps
// Package for the text glyph blit generator: command and register codes,
// character constants, sequencer states and divider types. No dependencies.
package tgb_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_TABLE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_GLYPH_WIDTH    = 2'd0;
  localparam logic [1:0] REG_GLYPH_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_GLYPHS_PER_ROW = 2'd2;

  // Register reset values.
  localparam logic [7:0] GLYPH_WIDTH_RST    = 8'd8;
  localparam logic [7:0] GLYPH_HEIGHT_RST   = 8'd16;
  localparam logic [7:0] GLYPHS_PER_ROW_RST = 8'd16;

  // Character codes with special handling.
  localparam logic [15:0] CP_NEWLINE   = 16'h000A;
  localparam logic [15:0] CP_TAB       = 16'h0009;
  localparam logic [15:0] CP_LATIN_LO  = 16'h0061;
  localparam logic [15:0] CP_LATIN_HI  = 16'h007A;
  localparam logic [15:0] CP_CYRIL_LO  = 16'h0430;
  localparam logic [15:0] CP_CYRIL_HI  = 16'h044F;
  localparam logic [15:0] CP_CASE_STEP = 16'h0020;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_MULX,
    ST_MULY,
    ST_DONE
  } tgb_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } tgb_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
    logic [7:0]  remainder;
  } tgb_div_res_t;

endpackage

>>> rtl/tgb_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the text glyph blit generator: command input,
// blit result output and configuration write. No dependencies.
interface tgb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [15:0]        code_point;
  logic [15:0]        glyph_index;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;

  modport source(output valid, cmd, code_point, glyph_index, origin_x, origin_y,
                 input ready);
  modport sink(input valid, cmd, code_point, glyph_index, origin_x, origin_y,
               output ready);
endinterface

interface tgb_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        src_x;
  logic [15:0]        src_y;
  logic signed [15:0] dst_x;
  logic signed [15:0] dst_y;

  modport source(output valid, src_x, src_y, dst_x, dst_y, input ready);
  modport sink(input valid, src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface tgb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_idx;
  logic [7:0] wdata;

  modport source(output valid, reg_idx, wdata, input ready);
  modport sink(input valid, reg_idx, wdata, output ready);
endinterface

>>> rtl/tgb_div.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, 16-bit dividend by 8-bit nonzero divisor,
// one quotient bit per cycle. Depends on tgb_pkg.
module tgb_div
  import tgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tgb_div_req_t req,
  output tgb_div_res_t res
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [15:0] quo_r;
  logic [7:0]  rem_r;

  logic [8:0]  trial;
  logic        ge;
  logic [8:0]  diff;
  logic [7:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[15]};
    ge      = (trial >= {1'b0, req.divisor});
    diff    = trial - {1'b0, req.divisor};
    rem_nxt = ge ? diff[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[14:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

>>> rtl/text_glyph_blit_generator.sv
`timescale 1ns / 1ps
// Text glyph blit generator, top level. Start, table-write, newline, tab and
// unused commands are done on acceptance. A drawn character passes lookup,
// the 16-step divider (skipped at zero row length), two multiply states and
// a done state that waits for a free output; the next transaction is taken in
// the cycle after the result is loaded. After reset the glyph table is cleared
// one entry per cycle while no command is taken; config writes are taken always.
module text_glyph_blit_generator
  import tgb_pkg::*;
#(
  parameter int CODE_POINTS = 65536
) (
  input logic      clk,
  input logic      rst_n,
  tgb_in_if.sink   in_ch,
  tgb_out_if.source out_ch,
  tgb_cfg_if.sink  cfg_ch
);

  // Table address width follows from the number of code points kept.
  localparam int AW = $clog2(CODE_POINTS);

  // ---------------------------------------------------------------------
  // Configuration registers. The port never stalls a write.
  // ---------------------------------------------------------------------
  logic [7:0] glyph_width_r;
  logic [7:0] glyph_height_r;
  logic [7:0] glyphs_per_row_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r    <= GLYPH_WIDTH_RST;
      glyph_height_r   <= GLYPH_HEIGHT_RST;
      glyphs_per_row_r <= GLYPHS_PER_ROW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_idx)
        REG_GLYPH_WIDTH:    glyph_width_r    <= cfg_ch.wdata;
        REG_GLYPH_HEIGHT:   glyph_height_r   <= cfg_ch.wdata;
        REG_GLYPHS_PER_ROW: glyphs_per_row_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state and datapath registers.
  // ---------------------------------------------------------------------
  tgb_state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r;
  logic [15:0]   cursor_x_r;
  logic [15:0]   cursor_y_r;
  logic [15:0]   line_start_x_r;
  logic [15:0]   rd_data_r;
  logic          rd_ok_r;
  logic [15:0]   col_r;
  logic [15:0]   row_r;
  logic [15:0]   prod_x_r;
  logic [15:0]   prod_y_r;

  logic          out_valid_r;
  logic [15:0]   out_src_x_r;
  logic [15:0]   out_src_y_r;
  logic [15:0]   out_dst_x_r;
  logic [15:0]   out_dst_y_r;

  // Handshake and decode of the incoming transaction.
  logic        in_take;
  logic        is_start;
  logic        is_char;
  logic        is_table;
  logic        is_newline;
  logic        is_tab;
  logic        is_glyph;
  logic [15:0] cp_folded;
  logic        wr_in_range;
  logic        rd_in_range;

  // The output register is free when empty or when its result leaves now.
  logic out_free;
  logic out_load;

  assign out_free = !out_valid_r || out_ch.ready;

  // A new transaction is taken only while the sequencer waits in idle.
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    in_take    = in_ch.valid && in_ch.ready;
    is_start   = in_take && (in_ch.cmd == CMD_START);
    is_char    = in_take && (in_ch.cmd == CMD_CHAR);
    is_table   = in_take && (in_ch.cmd == CMD_TABLE);
    is_newline = is_char && (in_ch.code_point == CP_NEWLINE);
    is_tab     = is_char && (in_ch.code_point == CP_TAB);
    is_glyph   = is_char && !is_newline && !is_tab;

    // Lowercase Latin and Cyrillic letters fold onto their capitals.
    if (in_ch.code_point inside {[CP_LATIN_LO:CP_LATIN_HI], [CP_CYRIL_LO:CP_CYRIL_HI]}) begin
      cp_folded = in_ch.code_point - CP_CASE_STEP;
    end else begin
      cp_folded = in_ch.code_point;
    end

    // Codes beyond a reduced table are dropped on write and read as glyph 0.
    wr_in_range = ({1'b0, in_ch.code_point} < 17'(CODE_POINTS));
    rd_in_range = ({1'b0, cp_folded} < 17'(CODE_POINTS));
  end

  // ---------------------------------------------------------------------
  // Glyph table memory: one write and one registered read per cycle.
  // The clearing sweep owns the write port right after reset.
  // ---------------------------------------------------------------------
  logic [15:0]   glyph_mem [CODE_POINTS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = is_table && wr_in_range;
      mem_wa = in_ch.code_point[AW-1:0];
      mem_wd = in_ch.glyph_index;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[mem_wa] <= mem_wd;
    end
    if (is_glyph) begin
      rd_data_r <= glyph_mem[cp_folded[AW-1:0]];
      rd_ok_r   <= rd_in_range;
    end
  end

  // ---------------------------------------------------------------------
  // The divider splits the glyph index into atlas row and column.
  // ---------------------------------------------------------------------
  tgb_div_req_t div_req;
  tgb_div_res_t div_res;
  logic [15:0]  glyph_idx;
  logic         div_start;

  assign glyph_idx = rd_ok_r ? rd_data_r : 16'd0;
  assign div_req   = {div_start, glyph_idx, glyphs_per_row_r};

  tgb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  // Shared 16x8 multiplier: column by width, then row by height.
  logic [15:0] mul_a;
  logic [7:0]  mul_b;
  logic [23:0] mul_p;

  always_comb begin
    if (state_r == ST_MULX) begin
      mul_a = col_r;
      mul_b = glyph_width_r;
    end else begin
      mul_a = row_r;
      mul_b = glyph_height_r;
    end
    mul_p = mul_a * mul_b;
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state and control outputs.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(CODE_POINTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_glyph) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // A row length of zero leaves the index whole as the column.
        if (glyphs_per_row_r == 8'd0) begin
          state_nxt = ST_MULX;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_MULX;
        end
      end
      ST_MULX: begin
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      col_r <= glyph_idx;
      row_r <= '0;
    end else if (state_r == ST_DIV && div_res.done) begin
      col_r <= {8'd0, div_res.remainder};
      row_r <= div_res.quotient;
    end
    if (state_r == ST_MULX) begin
      prod_x_r <= mul_p[15:0];
    end
    if (state_r == ST_MULY) begin
      prod_y_r <= mul_p[15:0];
    end
  end

  // Cursor state. The cursor advances before a glyph's destination is
  // taken, so a drawn glyph lands one cell right of the pre-advance cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      line_start_x_r <= '0;
    end else if (is_start) begin
      cursor_x_r     <= in_ch.origin_x;
      cursor_y_r     <= in_ch.origin_y;
      line_start_x_r <= in_ch.origin_x;
    end else if (is_newline) begin
      cursor_x_r <= line_start_x_r;
      cursor_y_r <= cursor_y_r + {8'd0, glyph_height_r};
    end else if (is_tab) begin
      cursor_x_r <= cursor_x_r + {7'd0, glyph_width_r, 1'b0};
    end else if (out_load) begin
      cursor_x_r <= cursor_x_r + {8'd0, glyph_width_r};
    end
  end

  // Output register: a finished result waits here while the next
  // transaction is already taken on the input side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_src_x_r <= prod_x_r;
      out_src_y_r <= prod_y_r;
      out_dst_x_r <= cursor_x_r + {8'd0, glyph_width_r};
      out_dst_y_r <= cursor_y_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.src_x = out_src_x_r;
  assign out_ch.src_y = out_src_y_r;
  assign out_ch.dst_x = out_dst_x_r;
  assign out_ch.dst_y = out_dst_y_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_glyph_blit_generator: randomized command
// stream with a built-in blit predictor and scoreboard. Depends on tgb_pkg,
// the channel interfaces in tgb_ifs.sv and the top-level RTL.
module testbench
  import tgb_pkg::*;
();

  // Command code 3 is not defined by the block; it must be dropped silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The glyph table is cleared entry by entry after reset with no command
  // accepted, so the quiet-cycle limit has to sit well above the table size.
  localparam int WATCHDOG_LIMIT = 300000;

  // Longest time a no-result command can still be in flight after the last
  // result has come out.
  localparam int SETTLE_CYCLES = 25;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        code_point;
    logic [15:0]        glyph_index;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } glyph_cmd_t;

  typedef struct packed {
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
  } blit_rect_t;

  logic clk;
  logic rst_n;

  tgb_in_if  in_bus ();
  tgb_out_if out_bus ();
  tgb_cfg_if cfg_bus ();

  text_glyph_blit_generator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Commands waiting to be driven, and blits the predictor says must come out.
  glyph_cmd_t cmd_q[$];
  blit_rect_t blit_q[$];

  // Shadow copy of the block's font registers and text state.
  logic [7:0]  font_w;
  logic [7:0]  font_h;
  logic [7:0]  font_per_row;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] margin_x;
  bit   [15:0] glyph_map [65536];

  int cmds_accepted;
  int blits_checked;
  int font_changes;
  int errors;
  int quiet_cycles;

  // Clock: 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random gaps on both channels are switched off for a stretch of commands
  // in the middle of the run, so back-to-back traffic is also exercised.
  function automatic bit gaps_enabled();
    return !(cmds_accepted >= 250 && cmds_accepted < 350);
  endfunction

  // Advances the shadow text state for one accepted command and, for a drawn
  // character, queues the blit the block has to produce.
  function automatic void predict_blit(input glyph_cmd_t c);
    logic [15:0] cp;
    logic [15:0] gidx;
    logic [15:0] col;
    logic [15:0] row;
    blit_rect_t  b;
    case (c.cmd)
      CMD_START: begin
        pen_x    = c.origin_x;
        margin_x = c.origin_x;
        pen_y    = c.origin_y;
      end
      CMD_TABLE: begin
        glyph_map[c.code_point] = c.glyph_index;
      end
      CMD_CHAR: begin
        cp = c.code_point;
        if (cp == CP_NEWLINE) begin
          // Carriage return plus line feed: back to the margin, one row down.
          pen_y = pen_y + font_h;
          pen_x = margin_x;
        end else if (cp == CP_TAB) begin
          pen_x = 16'(pen_x + 2 * font_w);
        end else begin
          // Lowercase Latin and Cyrillic share glyphs with their capitals.
          if ((cp >= CP_LATIN_LO && cp <= CP_LATIN_HI) ||
              (cp >= CP_CYRIL_LO && cp <= CP_CYRIL_HI)) begin
            cp = cp - CP_CASE_STEP;
          end
          gidx = glyph_map[cp];
          // With no row length set the atlas is one long strip.
          if (font_per_row == 8'd0) begin
            col = gidx;
            row = 16'd0;
          end else begin
            col = gidx % font_per_row;
            row = gidx / font_per_row;
          end
          // The pen moves first; the glyph is placed at the advanced position.
          pen_x    = pen_x + font_w;
          b.src_x  = 16'(col * font_w);
          b.src_y  = 16'(row * font_h);
          b.dst_x  = pen_x;
          b.dst_y  = pen_y;
          blit_q.push_back(b);
        end
      end
      default: ;
    endcase
  endfunction

  // Input driver. When the channel is empty or its transaction is taken at this
  // edge, a queued command is loaded unless a gap is drawn; valid is assigned once.
  always @(posedge clk) begin : cmd_driver
    glyph_cmd_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        nxt.cmd         = in_bus.cmd;
        nxt.code_point  = in_bus.code_point;
        nxt.glyph_index = in_bus.glyph_index;
        nxt.origin_x    = in_bus.origin_x;
        nxt.origin_y    = in_bus.origin_y;
        predict_blit(nxt);
        cmds_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (cmd_q.size() != 0 && !(gaps_enabled() && $urandom_range(99) < 16)) begin
          nxt = cmd_q.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.cmd         <= nxt.cmd;
          in_bus.code_point  <= nxt.code_point;
          in_bus.glyph_index <= nxt.glyph_index;
          in_bus.origin_x    <= nxt.origin_x;
          in_bus.origin_y    <= nxt.origin_y;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 'h%h, actual 'h%h", $time, name, want, got);
    end
  endtask

  // Output monitor: every blit transaction is compared with the oldest
  // prediction. Outside the gap-free stretch, ready is dropped at random to stall the block.
  always @(posedge clk) begin : blit_monitor
    blit_rect_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        blits_checked++;
        if (blit_q.size() == 0) begin
          errors++;
          $display("%0t ns: blit with none expected, expected nothing, actual %h %h %h %h",
                   $time, out_bus.src_x, out_bus.src_y, out_bus.dst_x, out_bus.dst_y);
        end else begin
          want = blit_q.pop_front();
          check_field("src_x", want.src_x, out_bus.src_x);
          check_field("src_y", want.src_y, out_bus.src_y);
          check_field("dst_x", want.dst_x, out_bus.dst_x);
          check_field("dst_y", want.dst_y, out_bus.dst_y);
        end
      end
      out_bus.ready <= !(gaps_enabled() && $urandom_range(99) < 16);
    end
  end

  // Watchdog: ends the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void queue_cmd(input logic [1:0] c, input logic [15:0] cp,
                                    input logic [15:0] gi, input logic [15:0] ox,
                                    input logic [15:0] oy);
    glyph_cmd_t g;
    g.cmd         = c;
    g.code_point  = cp;
    g.glyph_index = gi;
    g.origin_x    = ox;
    g.origin_y    = oy;
    cmd_q.push_back(g);
  endfunction

  function automatic logic [15:0] any_word();
    return 16'($urandom);
  endfunction

  // Letters of both cases in both scripts, with the odd stray code point.
  function automatic logic [15:0] pick_letter();
    case ($urandom_range(9))
      0, 1, 2: return 16'h0041 + 16'($urandom_range(25));
      3, 4, 5: return 16'h0061 + 16'($urandom_range(25));
      6, 7:    return 16'h0410 + 16'($urandom_range(63));
      8:       return 16'h0040 + 16'($urandom_range(63));
      default: return any_word();
    endcase
  endfunction

  // Table addresses favor the capitals that folded lowercase also reaches.
  function automatic logic [15:0] pick_slot();
    case ($urandom_range(4))
      0, 1:    return 16'h0041 + 16'($urandom_range(25));
      2, 3:    return 16'h0410 + 16'($urandom_range(31));
      default: return any_word();
    endcase
  endfunction

  function automatic logic [15:0] pick_origin();
    if ($urandom_range(1) == 0) return any_word();
    return 16'($urandom_range(1023)) - 16'd512;
  endfunction

  // Random text: mostly table fills and characters drawn against them, with
  // restarts, line breaks, tabs and a little of the unused command mixed in.
  // Unused commands are not counted, since the block simply drops them.
  task automatic queue_random(input int n);
    int made;
    int r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_cmd(CMD_UNUSED, any_word(), any_word(), any_word(), any_word());
      end else begin
        made++;
        if (r < 12) begin
          queue_cmd(CMD_START, any_word(), any_word(), pick_origin(), pick_origin());
        end else if (r < 32) begin
          queue_cmd(CMD_TABLE, pick_slot(),
                    ($urandom_range(4) == 0) ? any_word() : 16'($urandom_range(1023)),
                    any_word(), any_word());
        end else if (r < 40) begin
          queue_cmd(CMD_CHAR, CP_NEWLINE, any_word(), any_word(), any_word());
        end else if (r < 46) begin
          queue_cmd(CMD_CHAR, CP_TAB, any_word(), any_word(), any_word());
        end else begin
          queue_cmd(CMD_CHAR, pick_letter(), any_word(), any_word(), any_word());
        end
      end
    end
  endtask

  // Lets the sender run dry and waits for every predicted blit, then gives
  // a command that makes no blit time to finish before the block is idle.
  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_bus.valid || blit_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three font registers back to back; valid stays high between
  // writes and drops only after the last transaction.
  task automatic program_font(input logic [7:0] w, input logic [7:0] h,
                              input logic [7:0] per_row);
    logic [1:0] idx_list [3];
    logic [7:0] val_list [3];
    idx_list = '{REG_GLYPH_WIDTH, REG_GLYPH_HEIGHT, REG_GLYPHS_PER_ROW};
    val_list = '{w, h, per_row};
    @(posedge clk);
    for (int r = 0; r < 3; r++) begin
      cfg_bus.valid   <= 1'b1;
      cfg_bus.reg_idx <= idx_list[r];
      cfg_bus.wdata   <= val_list[r];
      do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
      case (idx_list[r])
        REG_GLYPH_WIDTH:    font_w       = val_list[r];
        REG_GLYPH_HEIGHT:   font_h       = val_list[r];
        REG_GLYPHS_PER_ROW: font_per_row = val_list[r];
        default: ;
      endcase
    end
    cfg_bus.valid <= 1'b0;
    font_changes++;
  endtask

  // Font settings visited after the directed part: both extremes, the zero
  // width, height and row length case, lopsided shapes and odd row lengths.
  logic [7:0] font_sets [7][3] = '{
    '{8'd1,   8'd1,   8'd1},
    '{8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0},
    '{8'd3,   8'd5,   8'd0},
    '{8'd255, 8'd1,   8'd3},
    '{8'd1,   8'd255, 8'd255},
    '{8'd7,   8'd13,  8'd10}
  };

  initial begin : stimulus
    // Every input of the block is known from time zero.
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_START;
    in_bus.code_point   = '0;
    in_bus.glyph_index  = '0;
    in_bus.origin_x     = '0;
    in_bus.origin_y     = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_idx     = REG_GLYPH_WIDTH;
    cfg_bus.wdata       = '0;
    font_w              = GLYPH_WIDTH_RST;
    font_h              = GLYPH_HEIGHT_RST;
    font_per_row        = GLYPHS_PER_ROW_RST;
    pen_x               = '0;
    pen_y               = '0;
    margin_x            = '0;
    cmds_accepted       = 0;
    blits_checked       = 0;
    font_changes        = 0;
    errors              = 0;
    quiet_cycles        = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset font. The first character reads a table
    // entry that only the clearing pass has touched.
    queue_cmd(CMD_CHAR,  16'h0041, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_START, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    queue_cmd(CMD_TABLE, 16'h0041, 16'hFFFF, 16'h0000, 16'h0000);
    queue_cmd(CMD_TABLE, 16'h0410, 16'd37,   16'h0000, 16'h0000);
    queue_cmd(CMD_TABLE, 16'hFFFF, 16'h1234, 16'h0000, 16'h0000);
    queue_cmd(CMD_TABLE, 16'h0000, 16'd5,    16'h0000, 16'h0000);
    queue_cmd(CMD_TABLE, 16'h0060, 16'd100,  16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h0061, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h007A, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h0430, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h044F, 16'h0000, 16'h0000, 16'h0000);
    // Codes just outside the lowercase ranges are not folded.
    queue_cmd(CMD_CHAR,  16'h0060, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h007B, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h0450, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    // Code point zero is drawn like any other character.
    queue_cmd(CMD_CHAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  CP_TAB,     16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  CP_NEWLINE, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(CMD_CHAR,  16'h0041, 16'h0000, 16'h0000, 16'h0000);
    // Origins at the other extremes; the pen wraps around in both axes.
    queue_cmd(CMD_START, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
    queue_cmd(CMD_CHAR,  CP_NEWLINE, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_START, 16'h0000, 16'h0000, 16'hFFFC, 16'hFFFF);
    queue_cmd(CMD_CHAR,  16'h0410, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(CMD_CHAR,  16'h0041, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Random phases. Each one starts with the block idle and the sender
    // paused until every blit has come back, then changes the font.
    for (int p = 0; p < 9; p++) begin
      if (p < 7) begin
        program_font(font_sets[p][0], font_sets[p][1], font_sets[p][2]);
      end else begin
        program_font(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(1, 255)));
      end
      @(negedge clk);
      queue_random(61);
      drain();
    end

    if (blit_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d blits never arrived", $time, blit_q.size());
    end
    $display("Checked %0d blits from %0d accepted commands across %0d font settings,",
             blits_checked, cmds_accepted, font_changes + 1);
    $display("including case folding, line breaks, tabs, wraparound and zero row length.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> text_glyph_blit_generator.f
rtl/tgb_pkg.sv
rtl/tgb_ifs.sv
rtl/tgb_div.sv
rtl/text_glyph_blit_generator.sv
tb/testbench.sv
